// ----- sv/vc2qfo_pkg.sv -----
// Package of types, constants and lookup functions for the VC-2 quantiser factor block.
package vc2qfo_pkg;

  localparam int QINDEX_W = 7;
  localparam int LEVEL_W = 3;
  localparam int SUBBAND_W = 2;
  localparam int FACTOR_W = 31;
  localparam int ADJ_W = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 3;
  localparam int FACTOR_ROM_DEPTH = 2 ** QINDEX_W;

  typedef logic [QINDEX_W-1:0] qindex_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [SUBBAND_W-1:0] subband_t;
  typedef logic [FACTOR_W-1:0] qfactor_t;
  typedef logic [ADJ_W-1:0] adj_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_index_t REG_WAVELET_FILTER = 2'd0;
  localparam cfg_index_t REG_TRANSFORM_DEPTH = 2'd1;

  localparam cfg_data_t FILTER_HAAR_NO_SHIFT = 3'd3;
  localparam cfg_data_t FILTER_LAST = 3'd6;
  localparam cfg_data_t MAX_DEPTH = 3'd4;

  localparam subband_t SB_LL = 2'd0;
  localparam subband_t SB_HL = 2'd1;
  localparam subband_t SB_LH = 2'd2;
  localparam subband_t SB_HH = 2'd3;

  localparam logic [1:0] PHASE_Q0 = 2'd0;
  localparam logic [1:0] PHASE_Q1 = 2'd1;
  localparam logic [1:0] PHASE_Q2 = 2'd2;

  localparam logic [63:0] MUL_Q1 = 64'd503829;
  localparam logic [63:0] RND_Q1 = 64'd52958;
  localparam logic [63:0] DIV_Q1 = 64'd105917;
  localparam logic [63:0] MUL_Q2 = 64'd665857;
  localparam logic [63:0] RND_Q2 = 64'd58854;
  localparam logic [63:0] DIV_Q2 = 64'd117708;
  localparam logic [63:0] MUL_Q3 = 64'd440253;
  localparam logic [63:0] RND_Q3 = 64'd32722;
  localparam logic [63:0] DIV_Q3 = 64'd65444;

  localparam qfactor_t OFFSET_INDEX0 = 31'd1;
  localparam qfactor_t OFFSET_INDEX1 = 31'd2;
  localparam qfactor_t OFFSET_BIAS = 31'd2;

  localparam adj_t ADJ_TABLE [7][5][4] = '{
    '{'{5'd5, 5'd0, 5'd0, 5'd0}, '{5'd0, 5'd3, 5'd3, 5'd0}, '{5'd0, 5'd4, 5'd4, 5'd1},
      '{5'd0, 5'd5, 5'd5, 5'd2}, '{5'd0, 5'd6, 5'd6, 5'd3}},
    '{'{5'd4, 5'd0, 5'd0, 5'd0}, '{5'd0, 5'd2, 5'd2, 5'd0}, '{5'd0, 5'd4, 5'd4, 5'd2},
      '{5'd0, 5'd5, 5'd5, 5'd3}, '{5'd0, 5'd7, 5'd7, 5'd5}},
    '{'{5'd5, 5'd0, 5'd0, 5'd0}, '{5'd0, 5'd3, 5'd3, 5'd0}, '{5'd0, 5'd4, 5'd4, 5'd1},
      '{5'd0, 5'd5, 5'd5, 5'd2}, '{5'd0, 5'd6, 5'd6, 5'd3}},
    '{'{5'd0, 5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0, 5'd0},
      '{5'd0, 5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0, 5'd0}},
    '{'{5'd8, 5'd0, 5'd0, 5'd0}, '{5'd0, 5'd4, 5'd4, 5'd0}, '{5'd0, 5'd4, 5'd4, 5'd0},
      '{5'd0, 5'd4, 5'd4, 5'd0}, '{5'd0, 5'd4, 5'd4, 5'd0}},
    '{'{5'd0, 5'd0, 5'd0, 5'd0}, '{5'd0, 5'd4, 5'd4, 5'd8}, '{5'd0, 5'd8, 5'd8, 5'd12},
      '{5'd0, 5'd13, 5'd13, 5'd17}, '{5'd0, 5'd17, 5'd17, 5'd21}},
    '{'{5'd3, 5'd0, 5'd0, 5'd0}, '{5'd0, 5'd1, 5'd1, 5'd0}, '{5'd0, 5'd4, 5'd4, 5'd2},
      '{5'd0, 5'd6, 5'd6, 5'd5}, '{5'd0, 5'd9, 5'd9, 5'd7}}
  };

  // The Haar filter without shift depends on the depth, so it is worked out here.
  function automatic adj_t adjustment(cfg_data_t filt, cfg_data_t depth, level_t lvl,
                                      subband_t sb);
    adj_t d5;
    adj_t l5;
    adj_t r;
    d5 = {2'b00, depth};
    l5 = {2'b00, lvl};
    r = '0;
    if (filt > FILTER_LAST || depth == '0 || depth > MAX_DEPTH || lvl > depth) begin
      r = '0;
    end else if (filt == FILTER_HAAR_NO_SHIFT) begin
      if (lvl == '0) begin
        r = (sb == SB_LL) ? adj_t'((d5 << 2) + 5'd4) : '0;
      end else if (sb == SB_HL || sb == SB_LH) begin
        r = adj_t'((d5 - l5 + 5'd1) << 2);
      end else if (sb == SB_HH) begin
        r = adj_t'((d5 - l5) << 2);
      end
    end else begin
      r = ADJ_TABLE[filt][lvl][sb];
    end
    return r;
  endfunction

  // Evaluated at elaboration only, to fill the factor table.
  function automatic qfactor_t factor_of(qindex_t i);
    logic [63:0] b;
    logic [63:0] f;
    b = 64'd1 << i[QINDEX_W-1:2];
    case (i[1:0])
      PHASE_Q0: f = b << 2;
      PHASE_Q1: f = (MUL_Q1 * b + RND_Q1) / DIV_Q1;
      PHASE_Q2: f = (MUL_Q2 * b + RND_Q2) / DIV_Q2;
      default:  f = (MUL_Q3 * b + RND_Q3) / DIV_Q3;
    endcase
    return f[FACTOR_W-1:0];
  endfunction

endpackage

// ----- sv/vc2qfo_ifs.sv -----
// Handshake interfaces for the index, result and configuration channels.
interface vc2qfo_in_if;
  import vc2qfo_pkg::*;
  logic     valid;
  logic     ready;
  qindex_t  qindex;
  level_t   level;
  subband_t subband;
  modport source (output valid, output qindex, output level, output subband, input ready);
  modport sink (input valid, input qindex, input level, input subband, output ready);
endinterface

interface vc2qfo_out_if;
  import vc2qfo_pkg::*;
  logic     valid;
  logic     ready;
  qfactor_t qfactor;
  qfactor_t qoffset;
  modport source (output valid, output qfactor, output qoffset, input ready);
  modport sink (input valid, input qfactor, input qoffset, output ready);
endinterface

interface vc2qfo_cfg_if;
  import vc2qfo_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/vc2_quant_factor_offset_top.sv -----
// Top level of the VC-2 quantiser factor and offset lookup pipeline.
//
//   channel   dir  word
//   cfg       in   register index, write data (always ready)
//   item      in   qindex, level, subband
//   result    out  qfactor, qoffset
//
// One word is accepted every cycle unless a result stall backs up to item; each result passes
// through three register stages: index adjustment, factor table read, offset add.
// Reset clears the stage valid bits and the two configuration registers.
// A stall holds full stages back from result to a gap; others still fill; no word is lost.
module vc2_quant_factor_offset_top #(
  parameter int unsigned MAX_QINDEX = 115
) (
  input logic         clk,
  input logic         rst,
  vc2qfo_cfg_if.sink  cfg,
  vc2qfo_in_if.sink   item,
  vc2qfo_out_if.source result
);
  import vc2qfo_pkg::*;

  cfg_data_t wavelet_filter;
  cfg_data_t transform_depth;

  logic     s1_valid, s2_valid, s3_valid;
  logic     en1, en2, en3;
  qindex_t  s1_qi;
  qfactor_t s2_factor;
  logic     s2_zero, s2_one;
  qfactor_t s3_factor, s3_offset;

  qindex_t  qsat, qi;
  adj_t     adj;
  qfactor_t offset_next;
  logic [FACTOR_W:0] half;

  qfactor_t factor_rom [FACTOR_ROM_DEPTH];

  for (genvar g = 0; g < FACTOR_ROM_DEPTH; g++) begin : g_rom
    localparam qfactor_t ENTRY = factor_of(QINDEX_W'(g));
    assign factor_rom[g] = ENTRY;
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wavelet_filter <= '0;
      transform_depth <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_WAVELET_FILTER) begin
        wavelet_filter <= cfg.data;
      end else if (cfg.index == REG_TRANSFORM_DEPTH) begin
        transform_depth <= cfg.data;
      end
    end
  end

  assign en3 = !s3_valid || result.ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign item.ready = en1;

  always_comb begin
    qsat = (item.qindex > QINDEX_W'(MAX_QINDEX)) ? QINDEX_W'(MAX_QINDEX) : item.qindex;
    adj = adjustment(wavelet_filter, transform_depth, item.level, item.subband);
    qi = (qsat > {2'b00, adj}) ? qindex_t'(qsat - {2'b00, adj}) : '0;
  end

  always_comb begin
    half = ({1'b0, s2_factor} + 32'd1) >> 1;
    if (s2_zero) begin
      offset_next = OFFSET_INDEX0 + OFFSET_BIAS;
    end else if (s2_one) begin
      offset_next = OFFSET_INDEX1 + OFFSET_BIAS;
    end else begin
      offset_next = half[FACTOR_W-1:0] + OFFSET_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= item.valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_qi <= qi;
    end
    if (en2) begin
      s2_factor <= factor_rom[s1_qi];
      s2_zero <= (s1_qi == qindex_t'(0));
      s2_one <= (s1_qi == qindex_t'(1));
    end
    if (en3) begin
      s3_factor <= s2_factor;
      s3_offset <= offset_next;
    end
  end

  assign result.valid = s3_valid;
  assign result.qfactor = s3_factor;
  assign result.qoffset = s3_offset;

endmodule

// ----- sv/vc2qfo_checker.sv -----
// Port-level checks on the quantiser factor pipeline, bound to the top level.
module vc2qfo_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input vc2qfo_pkg::qfactor_t qfactor,
  input vc2qfo_pkg::qfactor_t qoffset
);
  import vc2qfo_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(qfactor) && $stable(qoffset))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid straight after reset");

  a_flow: assert property (@(posedge clk) disable iff (rst) result_ready |-> item_ready)
    else $error("index channel stalled while result side is ready");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && result_ready) ##1 result_ready ##1 result_ready
    |=> result_valid)
    else $error("result missing three cycles after an accepted word");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (qoffset == qfactor_t'(({1'b0, qfactor} + 32'd1) >> 1) + OFFSET_BIAS)
                  || (qfactor == 31'd4 && qoffset == 31'd3)
                  || (qfactor == 31'd5 && qoffset == 31'd4))
    else $error("offset does not follow from factor");

endmodule

bind vc2_quant_factor_offset_top vc2qfo_checker u_vc2qfo_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .qfactor      (result.qfactor),
  .qoffset      (result.qoffset)
);

// ----- verif/tb_vc2_quant_factor_offset_top.sv -----
// Self-checking testbench for the VC-2 quantisation factor and offset lookup pipeline.
`timescale 1ns / 100ps

module tb_vc2_quant_factor_offset_top;
  import vc2qfo_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 12;
  localparam int WORDS_PER_PHASE = 128;
  localparam qindex_t SAT_QINDEX = 7'd115;

  localparam cfg_data_t FILT_DD97 = 3'd0;
  localparam cfg_data_t FILT_LEGALL = 3'd1;
  localparam cfg_data_t FILT_DD137 = 3'd2;
  localparam cfg_data_t FILT_HAAR1 = 3'd4;
  localparam cfg_data_t FILT_FIDELITY = 3'd5;
  localparam cfg_data_t FILT_DAUB97 = 3'd6;
  localparam cfg_data_t FILT_UNKNOWN = 3'd7;

  localparam logic [1:0] QTR_0 = 2'd0;
  localparam logic [1:0] QTR_1 = 2'd1;
  localparam logic [1:0] QTR_2 = 2'd2;

  localparam logic [63:0] QTR1_MUL = 64'd503829;
  localparam logic [63:0] QTR1_RND = 64'd52958;
  localparam logic [63:0] QTR1_DIV = 64'd105917;
  localparam logic [63:0] QTR2_MUL = 64'd665857;
  localparam logic [63:0] QTR2_RND = 64'd58854;
  localparam logic [63:0] QTR2_DIV = 64'd117708;
  localparam logic [63:0] QTR3_MUL = 64'd440253;
  localparam logic [63:0] QTR3_RND = 64'd32722;
  localparam logic [63:0] QTR3_DIV = 64'd65444;

  localparam logic [4:0] DEFAULT_ADJ [7][5][4] = '{
    '{'{5, 0, 0, 0}, '{0, 3, 3, 0}, '{0, 4, 4, 1}, '{0, 5, 5, 2}, '{0, 6, 6, 3}},
    '{'{4, 0, 0, 0}, '{0, 2, 2, 0}, '{0, 4, 4, 2}, '{0, 5, 5, 3}, '{0, 7, 7, 5}},
    '{'{5, 0, 0, 0}, '{0, 3, 3, 0}, '{0, 4, 4, 1}, '{0, 5, 5, 2}, '{0, 6, 6, 3}},
    '{'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}},
    '{'{8, 0, 0, 0}, '{0, 4, 4, 0}, '{0, 4, 4, 0}, '{0, 4, 4, 0}, '{0, 4, 4, 0}},
    '{'{0, 0, 0, 0}, '{0, 4, 4, 8}, '{0, 8, 8, 12}, '{0, 13, 13, 17}, '{0, 17, 17, 21}},
    '{'{3, 0, 0, 0}, '{0, 1, 1, 0}, '{0, 4, 4, 2}, '{0, 6, 6, 5}, '{0, 9, 9, 7}}
  };

  typedef struct {
    qindex_t  qindex;
    level_t   level;
    subband_t subband;
  } band_word_t;

  typedef struct {
    qfactor_t qfactor;
    qfactor_t qoffset;
  } quant_word_t;

  logic clk;
  logic rst;
  logic calm;
  int   cycles;
  int   errors;

  cfg_data_t cur_filter;
  cfg_data_t cur_depth;

  band_word_t  band_words[$];
  quant_word_t quant_words[$];

  vc2qfo_cfg_if cfg();
  vc2qfo_in_if  item();
  vc2qfo_out_if result();

  vc2_quant_factor_offset_top DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .result (result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [4:0] band_adjustment(cfg_data_t filt, cfg_data_t depth,
                                                 level_t lvl, subband_t sb);
    logic [4:0] d;
    logic [4:0] l;
    d = {2'b00, depth};
    l = {2'b00, lvl};
    if (filt > FILT_DAUB97 || depth == 3'd0 || depth > MAX_DEPTH || lvl > depth) begin
      return 5'd0;
    end
    if (filt == FILTER_HAAR_NO_SHIFT) begin
      if (lvl == 3'd0) begin
        return (sb == SB_LL) ? 5'((d << 2) + 5'd4) : 5'd0;
      end
      if (sb == SB_HL || sb == SB_LH) begin
        return 5'((d - l + 5'd1) << 2);
      end
      if (sb == SB_HH) begin
        return 5'((d - l) << 2);
      end
      return 5'd0;
    end
    return DEFAULT_ADJ[filt][lvl][sb];
  endfunction

  function automatic logic [63:0] factor_for(qindex_t qi);
    logic [63:0] scale;
    scale = 64'd1 << qi[6:2];
    case (qi[1:0])
      QTR_0: return scale << 2;
      QTR_1: return (QTR1_MUL * scale + QTR1_RND) / QTR1_DIV;
      QTR_2: return (QTR2_MUL * scale + QTR2_RND) / QTR2_DIV;
      default: return (QTR3_MUL * scale + QTR3_RND) / QTR3_DIV;
    endcase
  endfunction

  function automatic quant_word_t predict_quant(band_word_t w);
    qindex_t     qs;
    qindex_t     qi;
    logic [4:0]  adj;
    logic [63:0] f;
    logic [63:0] off;
    quant_word_t r;
    qs = (w.qindex > SAT_QINDEX) ? SAT_QINDEX : w.qindex;
    adj = band_adjustment(cur_filter, cur_depth, w.level, w.subband);
    qi = (qs > {2'b00, adj}) ? qs - {2'b00, adj} : 7'd0;
    f = factor_for(qi);
    if (qi == 7'd0) begin
      off = 64'd1;
    end else if (qi == 7'd1) begin
      off = 64'd2;
    end else begin
      off = (f + 64'd1) / 64'd2;
    end
    off = off + 64'd2;
    r.qfactor = f[FACTOR_W-1:0];
    r.qoffset = off[FACTOR_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    band_word_t w;
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        w.qindex = item.qindex;
        w.level = item.level;
        w.subband = item.subband;
        quant_words.push_back(predict_quant(w));
        void'(band_words.pop_front());
      end
      if (!item.valid || item.ready) begin
        if (band_words.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
          item.valid <= 1'b1;
          item.qindex <= band_words[0].qindex;
          item.level <= band_words[0].level;
          item.subband <= band_words[0].subband;
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    quant_word_t e;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (quant_words.size() == 0) begin
          $error("result word with nothing expected: qfactor %0d qoffset %0d",
                 result.qfactor, result.qoffset);
          errors++;
        end else begin
          e = quant_words.pop_front();
          if (result.qfactor !== e.qfactor) begin
            $error("qfactor expected %0d actual %0d", e.qfactor, result.qfactor);
            errors++;
          end
          if (result.qoffset !== e.qoffset) begin
            $error("qoffset expected %0d actual %0d", e.qoffset, result.qoffset);
            errors++;
          end
        end
      end
      result.ready <= calm || $urandom_range(99) >= 10;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_band(int q, int l, int s);
    band_word_t w;
    w.qindex = qindex_t'(q);
    w.level = level_t'(l);
    w.subband = subband_t'(s);
    band_words.push_back(w);
  endtask

  task automatic push_random_band();
    int pick;
    int q;
    int l;
    pick = $urandom_range(9);
    if (pick < 4) begin
      q = $urandom_range(127);
    end else if (pick < 8) begin
      q = $urandom_range(32);
    end else begin
      q = $urandom_range(127, 100);
    end
    l = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(7);
    push_band(q, l, $urandom_range(3));
  endtask

  task automatic wait_drained();
    while (band_words.size() != 0 || quant_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_index_t idx, cfg_data_t val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) begin
      @(posedge clk);
    end
    cfg.valid <= 1'b0;
    if (idx == REG_WAVELET_FILTER) begin
      cur_filter = val;
    end else if (idx == REG_TRANSFORM_DEPTH) begin
      cur_depth = val;
    end
  endtask

  task automatic set_config(cfg_data_t filt, cfg_data_t depth);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_WAVELET_FILTER, filt);
    write_reg(REG_TRANSFORM_DEPTH, depth);
  endtask

  initial begin
    cfg_data_t filt_list [RANDOM_PHASES];
    cfg_data_t depth_list [RANDOM_PHASES];
    filt_list = '{FILT_DD97, FILT_LEGALL, FILT_DD137, FILTER_HAAR_NO_SHIFT, FILT_HAAR1,
                  FILT_FIDELITY, FILT_DAUB97, FILT_UNKNOWN, FILTER_HAAR_NO_SHIFT,
                  FILT_LEGALL, FILT_DAUB97, FILT_FIDELITY};
    depth_list = '{3'd4, 3'd3, 3'd2, 3'd4, 3'd1, 3'd4, 3'd4, 3'd3, 3'd1, 3'd7, 3'd0, 3'd5};
    rst = 1'b1;
    calm = 1'b0;
    cur_filter = FILT_DD97;
    cur_depth = 3'd0;
    cfg.valid = 1'b0;
    cfg.index = REG_WAVELET_FILTER;
    cfg.data = 3'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration gives no adjustment, so these exercise the factor table directly.
    for (int q = 0; q < 8; q++) begin
      push_band(q, 0, SB_LL);
    end
    push_band(114, 4, SB_HH);
    push_band(115, 0, SB_HL);
    push_band(116, 2, SB_LH);
    push_band(127, 7, SB_HH);

    set_config(FILT_FIDELITY, 3'd4);
    push_band(10, 4, SB_HH);
    push_band(21, 4, SB_HH);
    push_band(127, 4, SB_HL);
    push_band(50, 5, SB_HH);
    push_band(127, 0, SB_LL);

    set_config(FILTER_HAAR_NO_SHIFT, 3'd4);
    push_band(20, 0, SB_LL);
    push_band(100, 0, SB_LL);
    push_band(30, 1, SB_HH);
    push_band(40, 2, SB_LH);
    push_band(9, 4, SB_HH);
    push_band(127, 4, SB_HL);

    set_config(FILT_UNKNOWN, 3'd2);
    push_band(3, 1, SB_HL);
    push_band(127, 2, SB_HH);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_config(filt_list[p], depth_list[p]);
      calm = (p == 3);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        push_random_band();
        if (p == 5 && n == WORDS_PER_PHASE / 2) begin
          wait_drained();
        end
      end
    end
    for (int p = 0; p < 3; p++) begin
      set_config(cfg_data_t'($urandom_range(7)), cfg_data_t'($urandom_range(7)));
      for (int n = 0; n < 10; n++) begin
        push_random_band();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/vc2qfo_pkg.sv
sv/vc2qfo_ifs.sv
sv/vc2_quant_factor_offset_top.sv
sv/vc2qfo_checker.sv
verif/tb_vc2_quant_factor_offset_top.sv
